@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define CHK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that the consequent holds in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CHK_ALWAYS(lbl, prop)
`define CHK_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/lphash_pkg.sv @@
package lphash_pkg;

    localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
    // Prime is 2^40 + 0x1b3: shift by 40 plus a narrow multiply
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
    localparam int          FNV_SHIFT    = 40;
    localparam logic [8:0]  CAP_RESET    = 9'd511;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [63:0] key_word;
        logic        key_last;
        logic [63:0] value_word;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot;
        logic [8:0]  order_index;
        logic [63:0] value_out;
    } rsp_t;

    typedef struct packed {
        logic        used;
        logic [63:0] hash;
        logic [63:0] value;
        logic [8:0]  order;
    } entry_t;

endpackage

@@ sv/linear_probe_hash_table_top.sv @@
// Linear-probing hash table keyed by an FNV-1a 64 hash of a streamed key.
// Command channel: an item (cmd) is taken when start is high and busy low.
// Each item carries one 64-bit key word; key_last marks the final word, on
// which the insert or lookup given by opcode runs with value_word.
// Result channel: one rsp per last word, shown for exactly one cycle while
// rsp_valid is high; the receiver cannot stall it. Other words give none.
// Config channel: cfg_data sets capacity (table uses 2*capacity+1 slots,
// clamped to TABLE_SLOTS); it is always ready. The user must write it only
// while idle; the block itself does not enforce this and takes it any time.
// Flow: the hash unit folds one byte a cycle, so a word that is not last
// keeps busy high while its bytes are folded. On a last word a restoring
// divider forms the home slot, then each probe goes through the registered
// memory read (S_PROBE, then S_EVAL); the next item can be taken at the edge
// that ends the strobe cycle.
// Reset: the block sweeps the slot memory clearing every slot, one slot a
// cycle, with busy high meanwhile. Capacity resets to 511, the entry count
// to zero, the longest probe to one.
`include "assert_macros.svh"

module linear_probe_hash_table_top #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lphash_pkg::cmd_t    cmd,
    output logic                rsp_valid,
    output lphash_pkg::rsp_t    rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [8:0]          cfg_data
);

    localparam int AW   = $clog2(TABLE_SLOTS);
    localparam int MW   = $clog2(TABLE_SLOTS + 1);
    localparam int SUMW = (MW > 10) ? MW + 1 : 11;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_DIV   = 6'b001000,
        S_PROBE = 6'b010000,
        S_EVAL  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [8:0]        cap_reg, cap_next;
    logic [63:0]       run_hash_reg, run_hash_next;
    logic [63:0]       word_reg, word_next;
    logic [2:0]        byte_cnt_reg, byte_cnt_next;
    logic [63:0]       div_reg, div_next;
    logic [5:0]        div_cnt_reg, div_cnt_next;
    logic [MW-1:0]     rem_reg, rem_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [MW-1:0]     probe_reg, probe_next;
    logic [9:0]        count_reg, count_next;
    logic [MW-1:0]     longest_reg, longest_next;
    logic              op_reg, op_next;
    logic              last_reg, last_next;
    logic [63:0]       value_reg, value_next;
    logic              rsp_valid_reg, rsp_valid_next;
    lphash_pkg::rsp_t  rsp_reg, rsp_next;

    lphash_pkg::entry_t mem [TABLE_SLOTS];
    lphash_pkg::entry_t rd_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    lphash_pkg::entry_t mem_wd;

    logic [63:0]       mix;
    logic [63:0]       hash_step;
    logic [SUMW-1:0]   m_raw;
    logic [MW-1:0]     m_val;
    logic [MW:0]       rem_shift;
    logic [MW:0]       rem_sub;
    logic [MW-1:0]     probe_inc;
    logic [AW-1:0]     idx_wrap;
    logic              table_full;

    // Shared FNV step: fold one byte, multiply by the prime
    assign mix       = run_hash_reg ^ {56'd0, word_reg[7:0]};
    assign hash_step = (mix << lphash_pkg::FNV_SHIFT) + (mix * 64'(lphash_pkg::FNV_PRIME_LO));

    // Slot count: twice capacity plus one, clamped to the memory depth
    assign m_raw = SUMW'({cap_reg, 1'b1});
    assign m_val = (m_raw > SUMW'(TABLE_SLOTS)) ? MW'(TABLE_SLOTS) : MW'(m_raw);

    // One restoring divider bit
    assign rem_shift = {rem_reg, div_reg[63]};
    assign rem_sub   = rem_shift - {1'b0, m_val};

    assign probe_inc  = probe_reg + MW'(1);
    assign idx_wrap   = ({1'b0, idx_reg} + (AW+1)'(1) == (AW+1)'(m_val)) ? '0
                                                                         : idx_reg + AW'(1);
    assign table_full = ({count_reg, 1'b0} >= 11'(m_val));

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        run_hash_next  = run_hash_reg;
        word_next      = word_reg;
        byte_cnt_next  = byte_cnt_reg;
        div_next       = div_reg;
        div_cnt_next   = div_cnt_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        probe_next     = probe_reg;
        count_next     = count_reg;
        longest_next   = longest_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        value_next     = value_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_wa         = idx_reg;
        mem_wd         = rd_reg;

        // Take a capacity write at any time
        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the memory, one slot a cycle
                mem_we        = 1'b1;
                mem_wa        = idx_reg;
                mem_wd        = '0;
                idx_next      = idx_reg + AW'(1);
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    word_next     = cmd.key_word;
                    op_next       = cmd.opcode;
                    last_next     = cmd.key_last;
                    value_next    = cmd.value_word;
                    byte_cnt_next = '0;
                    state_next    = S_HASH;
                end
            end
            S_HASH:
            begin
                // Fold one byte, low byte first
                run_hash_next = hash_step;
                word_next     = word_reg >> 8;
                byte_cnt_next = byte_cnt_reg + 3'd1;
                if (byte_cnt_reg == 3'd7)
                begin
                    if (last_reg)
                    begin
                        div_next      = hash_step;
                        div_cnt_next  = '0;
                        rem_next      = '0;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                // Home slot: one remainder bit a cycle
                div_next     = div_reg << 1;
                div_cnt_next = div_cnt_reg + 6'd1;
                rem_next     = rem_sub[MW] ? rem_shift[MW-1:0] : rem_sub[MW-1:0];
                if (div_cnt_reg == 6'd63)
                begin
                    idx_next   = rem_sub[MW] ? AW'(rem_shift[MW-1:0]) : AW'(rem_sub[MW-1:0]);
                    probe_next = '0;
                    if (op_reg == lphash_pkg::OP_INSERT && table_full)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{lphash_pkg::ST_FULL, 10'd0, 9'd0, 64'd0};
                        run_hash_next  = lphash_pkg::FNV_BASIS;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                // Memory read of the current slot is in flight
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                priority if (!rd_reg.used)
                begin
                    rsp_valid_next = 1'b1;
                    run_hash_next  = lphash_pkg::FNV_BASIS;
                    state_next     = S_IDLE;
                    if (op_reg == lphash_pkg::OP_INSERT)
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = '{1'b1, run_hash_reg, value_reg, count_reg[8:0]};
                        count_next = count_reg + 10'd1;
                        if (probe_inc > longest_reg)
                        begin
                            longest_next = probe_inc;
                        end
                        rsp_next = '{lphash_pkg::ST_INSERTED, 10'(idx_reg),
                                     count_reg[8:0], value_reg};
                    end
                    else
                    begin
                        rsp_next = '{lphash_pkg::ST_NOT_FOUND, 10'd0, 9'd0, 64'd0};
                    end
                end
                else if (rd_reg.hash == run_hash_reg)
                begin
                    rsp_valid_next = 1'b1;
                    run_hash_next  = lphash_pkg::FNV_BASIS;
                    state_next     = S_IDLE;
                    if (op_reg == lphash_pkg::OP_INSERT)
                    begin
                        mem_we       = 1'b1;
                        mem_wd.value = value_reg;
                        rsp_next = '{lphash_pkg::ST_UPDATED, 10'(idx_reg),
                                     rd_reg.order, value_reg};
                    end
                    else
                    begin
                        rsp_next = '{lphash_pkg::ST_FOUND, 10'(idx_reg),
                                     rd_reg.order, rd_reg.value};
                    end
                end
                else
                begin
                    // Advance to the next slot or give up
                    probe_next = probe_inc;
                    idx_next   = idx_wrap;
                    if (op_reg == lphash_pkg::OP_INSERT && probe_inc == m_val)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{lphash_pkg::ST_FULL, 10'd0, 9'd0, 64'd0};
                        run_hash_next  = lphash_pkg::FNV_BASIS;
                        state_next     = S_IDLE;
                    end
                    else if (op_reg == lphash_pkg::OP_LOOKUP && probe_inc >= longest_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{lphash_pkg::ST_NOT_FOUND, 10'd0, 9'd0, 64'd0};
                        run_hash_next  = lphash_pkg::FNV_BASIS;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cap_reg       <= lphash_pkg::CAP_RESET;
            run_hash_reg  <= lphash_pkg::FNV_BASIS;
            byte_cnt_reg  <= '0;
            div_cnt_reg   <= '0;
            idx_reg       <= '0;
            probe_reg     <= '0;
            count_reg     <= '0;
            longest_reg   <= MW'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            run_hash_reg  <= run_hash_next;
            byte_cnt_reg  <= byte_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            idx_reg       <= idx_next;
            probe_reg     <= probe_next;
            count_reg     <= count_next;
            longest_reg   <= longest_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        op_reg    <= op_next;
        last_reg  <= last_next;
        value_reg <= value_next;
        rsp_reg   <= rsp_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[idx_reg];
    end

    assign busy      = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    `CHK_NEXT(a_strobe_single, rsp_valid_reg, !rsp_valid_reg)
    `CHK_NEXT(a_take_busy, start && !busy, busy)
    `CHK_ALWAYS(a_count_bound, count_reg <= 10'd512)
    `CHK_ALWAYS(a_full_zero, !(rsp_valid_reg && rsp_reg.status == lphash_pkg::ST_FULL)
        || (rsp_reg.slot == 10'd0 && rsp_reg.value_out == 64'd0))
    `CHK_ALWAYS(a_longest_nonzero, longest_reg != '0)

endmodule

@@ dv/lphash_checker.sv @@
module lphash_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  lphash_pkg::cmd_t cmd,
    input  logic             rsp_valid,
    input  lphash_pkg::rsp_t rsp,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [8:0]       cfg_data,
    output int               mismatch_count,
    output int               awaited_count
);

    localparam int          SLOT_LIMIT = 1024;
    localparam logic [63:0] HASH_MULT  = 64'h0000_0100_0000_01b3;

    bit               tbl_used  [SLOT_LIMIT];
    logic [63:0]      tbl_hash  [SLOT_LIMIT];
    logic [63:0]      tbl_value [SLOT_LIMIT];
    logic [8:0]       tbl_order [SLOT_LIMIT];
    int               live_entries;
    int               probe_span;
    logic [63:0]      key_hash;
    logic [8:0]       capacity;
    lphash_pkg::rsp_t awaited_q[$];
    int               errors;

    assign mismatch_count = errors;
    assign awaited_count  = awaited_q.size();

    function automatic logic [63:0] fold_word(logic [63:0] h, logic [63:0] w);
        for (int b = 0; b < 8; b++)
        begin
            h = h ^ {56'd0, w[8*b +: 8]};
            h = h * HASH_MULT;
        end
        return h;
    endfunction

    function automatic int slots_in_use();
        int m;
        m = 2 * capacity + 1;
        return (m > SLOT_LIMIT) ? SLOT_LIMIT : m;
    endfunction

    // Insert or overwrite; full when past the entry limit or no slot is free
    function automatic lphash_pkg::rsp_t table_insert(logic [63:0] h, logic [63:0] v);
        int               m;
        int               i;
        int               walk_len;
        lphash_pkg::rsp_t r;
        m = slots_in_use();
        r = '0;
        r.status = lphash_pkg::ST_FULL;
        if (2 * live_entries >= m)
            return r;
        i = int'(h % 64'(m));
        walk_len = 1;
        for (int n = 0; n < m; n++)
        begin
            if (!tbl_used[i])
            begin
                tbl_used[i]  = 1'b1;
                tbl_hash[i]  = h;
                tbl_value[i] = v;
                tbl_order[i] = live_entries[8:0];
                live_entries = (live_entries + 1) & 10'h3ff;
                if (walk_len > probe_span)
                    probe_span = walk_len;
                r.status      = lphash_pkg::ST_INSERTED;
                r.slot        = i[9:0];
                r.order_index = tbl_order[i];
                r.value_out   = v;
                return r;
            end
            if (tbl_hash[i] == h)
            begin
                tbl_value[i]  = v;
                r.status      = lphash_pkg::ST_UPDATED;
                r.slot        = i[9:0];
                r.order_index = tbl_order[i];
                r.value_out   = v;
                return r;
            end
            walk_len++;
            i = (i + 1) % m;
        end
        return r;
    endfunction

    // Walk no further than the longest probe seen so far
    function automatic lphash_pkg::rsp_t table_lookup(logic [63:0] h);
        int               m;
        int               i;
        lphash_pkg::rsp_t r;
        m = slots_in_use();
        i = int'(h % 64'(m));
        r = '0;
        r.status = lphash_pkg::ST_NOT_FOUND;
        for (int n = 0; n < probe_span; n++)
        begin
            if (!tbl_used[i])
                break;
            if (tbl_hash[i] == h)
            begin
                r.status      = lphash_pkg::ST_FOUND;
                r.slot        = i[9:0];
                r.order_index = tbl_order[i];
                r.value_out   = tbl_value[i];
                return r;
            end
            i = (i + 1) % m;
        end
        return r;
    endfunction

    function automatic void report(string what, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        errors++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0]      h;
        lphash_pkg::rsp_t want;
        if (!rst_n)
        begin
            foreach (tbl_used[k])
                tbl_used[k] = 1'b0;
            live_entries = 0;
            probe_span   = 1;
            key_hash     = lphash_pkg::FNV_BASIS;
            capacity     = lphash_pkg::CAP_RESET;
            awaited_q.delete();
            errors       = 0;
        end
        else
        begin
            // Compare the result first: it cannot belong to this cycle's item
            if (rsp_valid)
            begin
                if (awaited_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (rsp.status != want.status)
                        report("status", want.status, rsp.status);
                    if (rsp.slot != want.slot)
                        report("slot", want.slot, rsp.slot);
                    if (rsp.order_index != want.order_index)
                        report("order_index", want.order_index, rsp.order_index);
                    if (rsp.value_out != want.value_out)
                        report("value_out", want.value_out, rsp.value_out);
                end
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            // Fold the accepted word; run the operation on the last one
            if (start && !busy)
            begin
                h = fold_word(key_hash, cmd.key_word);
                if (!cmd.key_last)
                    key_hash = h;
                else
                begin
                    key_hash = lphash_pkg::FNV_BASIS;
                    if (cmd.opcode == lphash_pkg::OP_INSERT)
                        awaited_q.push_back(table_insert(h, cmd.value_word));
                    else
                        awaited_q.push_back(table_lookup(h));
                end
            end
        end
    end

endmodule

@@ dv/tb_linear_probe_hash_table_top.sv @@
module tb_linear_probe_hash_table_top;

    localparam int KEY_POOL = 48;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    lphash_pkg::cmd_t cmd;
    logic             rsp_valid;
    lphash_pkg::rsp_t rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [8:0]       cfg_data;
    int               mismatch_count;
    int               awaited_count;

    logic [63:0] key_words [KEY_POOL][3];
    int          key_len   [KEY_POOL];
    int          words_sent;
    bit          gaps_on;

    linear_probe_hash_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lphash_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .rsp_valid      (rsp_valid),
        .rsp            (rsp),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Hold off until every result is in and the block has gone idle
    task automatic drain();
        while (awaited_count != 0 || busy)
            @(negedge clk);
    endtask

    task automatic set_capacity(logic [8:0] cap);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Send one key word; with gaps on, sometimes add a random idle burst beforehand
    task automatic send_word(logic op, logic [63:0] w, logic last, logic [63:0] v);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 11))
                @(negedge clk);
        end
        start = 1'b1;
        cmd   = '{opcode: op, key_word: w, key_last: last, value_word: v};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start = 1'b0;
        cmd   = '{opcode: logic'($urandom), key_word: rand_word(), key_last: 1'b0,
                  value_word: rand_word()};
        words_sent++;
    endtask

    task automatic send_key(int idx, logic op, logic [63:0] v);
        for (int k = 0; k < key_len[idx]; k++)
            send_word((k == key_len[idx] - 1) ? op : logic'($urandom),
                      key_words[idx][k], k == key_len[idx] - 1,
                      (k == key_len[idx] - 1) ? v : rand_word());
    endtask

    task automatic random_phase(logic [8:0] cap, int n_words);
        int   idx;
        int   stop;
        logic op;
        set_capacity(cap);
        stop = words_sent + n_words;
        while (words_sent < stop)
        begin
            op = ($urandom_range(0, 2) == 0) ? lphash_pkg::OP_LOOKUP : lphash_pkg::OP_INSERT;
            if ($urandom_range(0, 6) == 0)
            begin
                // Fresh key, mostly unseen; sometimes a single word
                repeat ($urandom_range(0, 2))
                    send_word(logic'($urandom), rand_word(), 1'b0, rand_word());
                send_word(op, rand_word(), 1'b1, rand_word());
            end
            else
            begin
                idx = $urandom_range(0, KEY_POOL - 1);
                send_key(idx, op, rand_word());
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        cfg_valid  = 1'b0;
        cfg_data   = lphash_pkg::CAP_RESET;
        words_sent = 0;
        gaps_on    = 1'b0;
        key_len[0] = 1;
        key_words[0][0] = '0;
        key_len[1] = 1;
        key_words[1][0] = '1;
        key_len[2] = 3;
        key_words[2][0] = '1;
        key_words[2][1] = '0;
        key_words[2][2] = 64'h8000_0000_0000_0001;
        for (int k = 3; k < KEY_POOL; k++)
        begin
            key_len[k] = $urandom_range(1, 3);
            for (int j = 0; j < 3; j++)
                key_words[k][j] = rand_word();
        end
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single slot table: one insert fits, the next reports full
        set_capacity(9'd0);
        send_key(0, lphash_pkg::OP_LOOKUP, '0);
        send_key(0, lphash_pkg::OP_INSERT, '1);
        send_key(0, lphash_pkg::OP_LOOKUP, '0);
        send_key(1, lphash_pkg::OP_INSERT, '0);
        send_key(0, lphash_pkg::OP_INSERT, 64'h1234);
        // Three slots: one more entry, then full even for a present key
        set_capacity(9'd1);
        send_key(1, lphash_pkg::OP_INSERT, '1);
        send_key(1, lphash_pkg::OP_INSERT, '0);
        send_key(2, lphash_pkg::OP_INSERT, '0);
        send_key(1, lphash_pkg::OP_LOOKUP, '0);
        // Widest table: multi-word keys, overwrite, found and not found
        set_capacity(9'd511);
        send_key(2, lphash_pkg::OP_INSERT, '1);
        send_key(2, lphash_pkg::OP_INSERT, '0);
        send_key(0, lphash_pkg::OP_INSERT, 64'h5555_aaaa_5555_aaaa);
        send_key(0, lphash_pkg::OP_LOOKUP, '0);
        send_key(2, lphash_pkg::OP_LOOKUP, '1);
        send_key(3, lphash_pkg::OP_LOOKUP, '0);

        gaps_on = 1'b1;
        random_phase(9'd511, 300);
        random_phase(9'd20, 150);
        random_phase(9'd300, 250);
        // Let everything settle once between phases before carrying on
        drain();
        random_phase(9'd511, 250);
        gaps_on = 1'b0;
        random_phase(9'd511, 250);

        drain();
        repeat (20)
            @(negedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
